### sv/hsf_pkg.sv
// ----------------------------------------------------------------------------
// hsf_pkg
// Shared widths, defaults, item codes and control types of the hyperedge
// superset finder.
// ----------------------------------------------------------------------------
package hsf_pkg;

  localparam int MODE_W        = 2;
  localparam int EDGE_IDX_W    = 5;
  localparam int VERTEX_IDX_W  = 6;
  localparam int MASK_W        = 32;

  localparam int EDGE_COUNT_DEF   = 32;
  localparam int VERTEX_COUNT_DEF = 64;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_QUERY = 2'd2
  } mode_t;

  // write-side controls of the edge store
  typedef struct packed {
    logic wr_en;   // write wr_data to wr_addr, mark entry valid
    logic clr_en;  // mark entry at wr_addr empty
  } store_ctl_t;

endpackage

### sv/hsf_if.sv
// ----------------------------------------------------------------------------
// hsf_in_if / hsf_out_if
// Valid/ready channels for query items and superset results.
// ----------------------------------------------------------------------------
interface hsf_in_if;
  logic                              valid;
  logic                              ready;
  logic [hsf_pkg::MODE_W-1:0]        mode;
  logic [hsf_pkg::EDGE_IDX_W-1:0]    edge_index;
  logic [hsf_pkg::VERTEX_IDX_W-1:0]  vertex_index;

  modport source (output valid, mode, edge_index, vertex_index, input ready);
  modport sink   (input valid, mode, edge_index, vertex_index, output ready);
endinterface

interface hsf_out_if;
  logic                        valid;
  logic                        ready;
  logic [hsf_pkg::MASK_W-1:0]  superset_mask;
  logic                        empty_error;

  modport source (output valid, superset_mask, empty_error, input ready);
  modport sink   (input valid, superset_mask, empty_error, output ready);
endinterface

### sv/hyperedge_superset_finder_unit.sv
// ----------------------------------------------------------------------------
// hyperedge_superset_finder_unit
// Edge family store with clear / add-vertex / superset-query items.
//
//   channel   dir  payload                                   transfer
//   in_chan   in   mode, edge_index, vertex_index            valid & ready
//   out_chan  out  superset_mask, empty_error (query only)   valid & ready
//
// Steps: clear drops the valid bit of the entry; add reads, then writes back;
// a query fetches the queried edge over the single read port of the edge store,
// then one stored edge per cycle for the compare. An empty query skips the
// scan; an out-of-range query goes straight to the result.
// Reset: valid bits of all entries drop at once; no clearing sweep.
// Stalls: results sit in an output register; a new item is taken while it
// waits, and a query only holds at its end if the previous result is untaken.
// ----------------------------------------------------------------------------
module hyperedge_superset_finder_unit #(
  parameter int EDGE_COUNT   = hsf_pkg::EDGE_COUNT_DEF,
  parameter int VERTEX_COUNT = hsf_pkg::VERTEX_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hsf_in_if.sink     in_chan,
  hsf_out_if.source  out_chan
);
  import hsf_pkg::*;

  localparam int MEM_DEPTH = (EDGE_COUNT < MASK_W) ? EDGE_COUNT : MASK_W;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int VW        = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

  typedef logic [VERTEX_COUNT-1:0] word_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ADD  = 5'b00010,
    ST_QRY  = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    edge_r, edge_nxt;
  word_t            bit_r, bit_nxt;
  word_t            y_r, y_nxt;
  logic [AW-1:0]    scan_idx_r, scan_idx_nxt;
  logic [MASK_W-1:0] mask_r, mask_nxt;
  logic             err_r, err_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0] out_mask_r;
  logic             out_err_r;
  logic             out_load;

  store_ctl_t       st_ctl;
  logic [AW-1:0]    st_wr_addr;
  word_t            st_wr_data;
  logic [AW-1:0]    st_rd_addr;
  word_t            rd_word;

  logic             in_xfer;
  logic             edge_ok;
  logic             vertex_ok;
  logic [AW-1:0]    in_addr;
  logic             scan_last;
  logic             hit;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign edge_ok       = int'(in_chan.edge_index) < MEM_DEPTH;
  assign vertex_ok     = int'(in_chan.vertex_index) < VERTEX_COUNT;
  assign in_addr       = in_chan.edge_index[AW-1:0];
  assign scan_last     = scan_idx_r == AW'(MEM_DEPTH - 1);
  assign hit           = (scan_idx_r != edge_r) && ((y_r & ~rd_word) == '0);
  assign out_load      = (state_r == ST_EMIT) && (!out_valid_r || out_chan.ready);

  hsf_edge_store #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (VERTEX_COUNT),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (st_ctl),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_addr (st_rd_addr),
    .rd_word (rd_word)
  );

  always_comb begin
    state_nxt    = state_r;
    edge_nxt     = edge_r;
    bit_nxt      = bit_r;
    y_nxt        = y_r;
    scan_idx_nxt = scan_idx_r;
    mask_nxt     = mask_r;
    err_nxt      = err_r;
    st_ctl       = '0;
    st_wr_addr   = edge_r;
    st_wr_data   = rd_word | bit_r;
    st_rd_addr   = edge_r;

    unique case (state_r)
      ST_IDLE: begin
        st_rd_addr = in_addr;
        st_wr_addr = in_addr;
        edge_nxt   = in_addr;
        bit_nxt    = word_t'(1) << in_chan.vertex_index[VW-1:0];
        if (in_xfer) begin
          unique case (in_chan.mode)
            MODE_CLEAR: st_ctl.clr_en = edge_ok;
            MODE_ADD: begin
              if (edge_ok && vertex_ok) begin
                state_nxt = ST_ADD;
              end
            end
            MODE_QUERY: begin
              if (edge_ok) begin
                state_nxt = ST_QRY;
              end else begin
                mask_nxt  = '0;
                err_nxt   = 1'b1;
                state_nxt = ST_EMIT;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        st_ctl.wr_en = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_QRY: begin
        st_rd_addr   = '0;
        y_nxt        = rd_word;
        mask_nxt     = '0;
        scan_idx_nxt = '0;
        if (rd_word == '0) begin
          err_nxt   = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          err_nxt   = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        st_rd_addr   = scan_last ? '0 : scan_idx_r + AW'(1);
        scan_idx_nxt = scan_idx_r + AW'(1);
        if (hit) begin
          mask_nxt = mask_r | (MASK_W'(1) << scan_idx_r);
        end
        if (scan_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    edge_r     <= edge_nxt;
    bit_r      <= bit_nxt;
    y_r        <= y_nxt;
    scan_idx_r <= scan_idx_nxt;
    mask_r     <= mask_nxt;
    err_r      <= err_nxt;
    if (out_load) begin
      out_mask_r <= mask_r;
      out_err_r  <= err_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.superset_mask = out_mask_r;
  assign out_chan.empty_error   = out_err_r;

endmodule

### sv/hsf_edge_store.sv
// ----------------------------------------------------------------------------
// hsf_edge_store
// Membership bitmaps of all edges: one synchronous memory with a registered
// read port and one write port, plus per-entry valid bits cleared at reset.
// An entry that is not valid reads as the empty set.
// ----------------------------------------------------------------------------
module hsf_edge_store #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 64,
  parameter int AW    = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  hsf_pkg::store_ctl_t     ctl,
  input  logic [AW-1:0]           wr_addr,
  input  logic [WIDTH-1:0]        wr_data,
  input  logic [AW-1:0]           rd_addr,
  output logic [WIDTH-1:0]        rd_word
);
  import hsf_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end else if (ctl.clr_en) begin
        vld_r[wr_addr] <= 1'b0;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_word = rd_vld_r ? rd_data_r : '0;

endmodule

### sv/hsf_checker.sv
// ----------------------------------------------------------------------------
// hsf_checker
// Port-level checks of the superset finder, bound to the top level.
// ----------------------------------------------------------------------------
module hsf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [hsf_pkg::MODE_W-1:0]        in_mode,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [hsf_pkg::MASK_W-1:0]        out_mask,
  input logic                              out_err
);
  import hsf_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mask) && $stable(out_err))
    else $error("result changed while stalled");

  // empty query carries a zero mask
  a_err_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_err |-> out_mask == '0)
    else $error("empty_error with nonzero mask");

  // a query transfer closes the input
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_QUERY |=> !in_ready)
    else $error("input open right after query transfer");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind hyperedge_superset_finder_unit hsf_checker u_hsf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_mode   (in_chan.mode),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_mask  (out_chan.superset_mask),
  .out_err   (out_chan.empty_error)
);

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for hyperedge_superset_finder_unit. A queue of pending
// items (directed corner cases, then random set-building sequences mixed
// with noise) feeds a bursty driver. Each accepted transfer updates a local
// copy of the edge store and queues the expected result of every query.
// A monitor behind a stalling receiver checks each result field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import hsf_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int NUM_EDGES      = EDGE_COUNT_DEF;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 60;

  typedef struct {
    logic [MODE_W-1:0]       mode;
    logic [EDGE_IDX_W-1:0]   eidx;
    logic [VERTEX_IDX_W-1:0] vidx;
  } edge_item_t;

  typedef struct {
    logic [MASK_W-1:0] mask;
    logic              empty;
  } superset_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hsf_in_if  in_chan ();
  hsf_out_if out_chan ();

  hyperedge_superset_finder_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #4 clk = ~clk;

  edge_item_t       pending_items[$];
  superset_result_t expected_supersets[$];
  logic [63:0]      edge_copy[NUM_EDGES];

  int sent_count = 0;
  int error_count = 0;
  int clear_count = 0;
  int add_count = 0;
  int query_count = 0;
  int empty_count = 0;
  int unused_count = 0;
  int hit_bits = 0;

  initial begin
    in_chan.valid        = 1'b0;
    in_chan.mode         = '0;
    in_chan.edge_index   = '0;
    in_chan.vertex_index = '0;
    out_chan.ready       = 1'b0;
    for (int i = 0; i < NUM_EDGES; i++) edge_copy[i] = '0;
  end

  // Local copy of the edge store; queues the answer of every query.
  function automatic void track_edge_item(input logic [MODE_W-1:0] m,
                                          input logic [EDGE_IDX_W-1:0] e,
                                          input logic [VERTEX_IDX_W-1:0] v);
    superset_result_t res;
    logic [63:0]      y;
    res.mask  = '0;
    res.empty = 1'b0;
    if (m == MODE_CLEAR) begin
      edge_copy[e] = '0;
      clear_count++;
    end else if (m == MODE_ADD) begin
      edge_copy[e][v] = 1'b1;
      add_count++;
    end else if (m == MODE_QUERY) begin
      query_count++;
      y = edge_copy[e];
      if (y == '0) begin
        res.empty = 1'b1;
        empty_count++;
      end else begin
        for (int x = 0; x < NUM_EDGES && x < MASK_W; x++) begin
          if (x != int'(e) && (y & ~edge_copy[x]) == '0) begin
            res.mask[x] = 1'b1;
            hit_bits++;
          end
        end
      end
      expected_supersets = {expected_supersets, res};
    end else begin
      unused_count++;
    end
  endfunction

  task automatic queue_item(input logic [MODE_W-1:0] m, input int e, input int v);
    edge_item_t it;
    it.mode = m;
    it.eidx = e[EDGE_IDX_W-1:0];
    it.vidx = v[VERTEX_IDX_W-1:0];
    pending_items = {pending_items, it};
  endtask

  // Sender: bursts of random length separated by random gaps.
  edge_item_t next_item;
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid        <= 1'b0;
      in_chan.mode         <= '0;
      in_chan.edge_index   <= '0;
      in_chan.vertex_index <= '0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        track_edge_item(in_chan.mode, in_chan.edge_index, in_chan.vertex_index);
        sent_count++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left > 0) begin
          in_chan.valid <= 1'b0;
          gap_left--;
        end else if (pending_items.size() > 0) begin
          next_item = pending_items.pop_front();
          in_chan.valid        <= 1'b1;
          in_chan.mode         <= next_item.mode;
          in_chan.edge_index   <= next_item.eidx;
          in_chan.vertex_index <= next_item.vidx;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
            case ($urandom_range(0, 3))
              0, 3:    gap_left = 0;
              1:       gap_left = $urandom_range(1, 3);
              default: gap_left = $urandom_range(4, 40);
            endcase
          end
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: segments of always-ready, coin-flip, long-stall and mostly-stalled behavior.
  int seg_left = 0;
  int ready_style = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left    = $urandom_range(50, 300);
        ready_style = $urandom_range(0, 3);
      end else begin
        seg_left--;
      end
      if (stall_left > 0) stall_left--;
      case (ready_style)
        0: out_chan.ready <= 1'b1;
        1: out_chan.ready <= 1'($urandom_range(0, 1));
        2: begin
          if (stall_left == 0 && $urandom_range(0, 19) == 0)
            stall_left = $urandom_range(5, 60);
          out_chan.ready <= (stall_left == 0);
        end
        default: out_chan.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Result checker.
  superset_result_t want;

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_supersets.size() == 0) begin
        $error("unexpected result: superset_mask %h empty_error %b",
               out_chan.superset_mask, out_chan.empty_error);
        error_count++;
      end else begin
        want = expected_supersets.pop_front();
        if (out_chan.superset_mask !== want.mask) begin
          $error("superset_mask: expected %h, actual %h", want.mask,
                 out_chan.superset_mask);
          error_count++;
        end
        if (out_chan.empty_error !== want.empty) begin
          $error("empty_error: expected %b, actual %b", want.empty,
                 out_chan.empty_error);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int total;
    int sel;
    int pool_size;
    int pool[8];
    int edges_used[6];
    int n_edges;
    int n_adds;

    // corner cases
    queue_item(MODE_QUERY, 0, 0);
    queue_item(MODE_ADD, 0, 0);
    queue_item(MODE_ADD, 0, 63);
    queue_item(MODE_ADD, 31, 0);
    queue_item(MODE_ADD, 31, 63);
    queue_item(MODE_QUERY, 0, 0);
    queue_item(MODE_QUERY, 31, 63);
    queue_item(MODE_ADD, 1, 5);
    queue_item(MODE_QUERY, 1, 0);
    queue_item(MODE_ADD, 0, 5);
    queue_item(MODE_QUERY, 1, 0);
    queue_item(MODE_UNUSED, 1, 6);
    queue_item(MODE_QUERY, 1, 0);
    queue_item(MODE_CLEAR, 31, 0);
    queue_item(MODE_QUERY, 31, 0);
    queue_item(MODE_QUERY, 0, 0);
    queue_item(MODE_CLEAR, 31, 63);
    queue_item(MODE_ADD, 30, 5);
    queue_item(MODE_ADD, 29, 5);
    queue_item(MODE_QUERY, 1, 0);
    queue_item(MODE_CLEAR, 0, 0);
    queue_item(MODE_CLEAR, 1, 0);
    queue_item(MODE_UNUSED, 31, 63);
    queue_item(MODE_QUERY, 30, 0);

    // random: small vertex pools make subset relations likely
    while (pending_items.size() < RANDOM_ITEMS + 24) begin
      sel = $urandom_range(0, 9);
      if (sel < 8) begin
        pool_size = $urandom_range(1, 6);
        for (int i = 0; i < pool_size; i++) begin
          case ($urandom_range(0, 7))
            0:       pool[i] = 0;
            1:       pool[i] = 63;
            default: pool[i] = $urandom_range(0, 63);
          endcase
        end
        n_edges = $urandom_range(1, 6);
        for (int i = 0; i < n_edges; i++) begin
          edges_used[i] = $urandom_range(0, 31);
          if ($urandom_range(0, 1)) queue_item(MODE_CLEAR, edges_used[i], $urandom_range(0, 63));
          n_adds = $urandom_range(1, pool_size);
          for (int k = 0; k < n_adds; k++)
            queue_item(MODE_ADD, edges_used[i], pool[$urandom_range(0, pool_size - 1)]);
        end
        for (int q = $urandom_range(1, 3); q > 0; q--) begin
          if ($urandom_range(0, 3) == 0)
            queue_item(MODE_QUERY, $urandom_range(0, 31), $urandom_range(0, 63));
          else
            queue_item(MODE_QUERY, edges_used[$urandom_range(0, n_edges - 1)],
                       $urandom_range(0, 63));
        end
      end else begin
        for (int i = $urandom_range(3, 10); i > 0; i--)
          queue_item(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 31),
                     $urandom_range(0, 63));
      end
    end
    total = pending_items.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_count < total) @(posedge clk);
    while (expected_supersets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items: %0d clears, %0d adds, %0d ignored (unused mode)",
             sent_count, clear_count, add_count, unused_count);
    $display("%0d queries, %0d on empty edges, %0d superset hits in total",
             query_count, empty_count, hit_bits);
    if (error_count == 0 && expected_supersets.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
